### rtl/tssd_pkg.sv
// shared types, constants and the crc-8 step for the scratchpad decoder
// no dependencies; every other file imports this package
`default_nettype none

package tssd_pkg;

    localparam int unsigned FRAME_BYTES = 9;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned LAST_IDX    = FRAME_BYTES - 1;

    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

    localparam logic [7:0] RES_CODE_9  = 8'h1F;
    localparam logic [7:0] RES_CODE_10 = 8'h3F;
    localparam logic [7:0] RES_CODE_11 = 8'h5F;
    localparam logic [7:0] RES_CODE_12 = 8'h7F;

    localparam logic [9:0] SCALE_9  = 10'd500;
    localparam logic [9:0] SCALE_10 = 10'd250;
    localparam logic [9:0] SCALE_11 = 10'd125;
    // 625/10 is 125/2: multiply by 125 and drop one bit
    localparam logic [9:0] SCALE_12 = 10'd125;

    localparam int unsigned MDEG_W      = 22;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_CRC = 2'd1,
        ST_RES = 2'd2
    } t_status;

    // one finished frame handed from the front end to the scaler
    typedef struct packed {
        logic        crc_ok;
        logic [7:0]  res_byte;
        logic [15:0] raw;
    } t_job;

    function automatic logic [7:0] crc8_update(input logic [7:0] acc_in,
                                               input logic [7:0] data_in);
        logic [7:0] acc;
        logic [7:0] d;
        logic       mix;
        acc = acc_in;
        d   = data_in;
        for (int k = 0; k < 8; k++) begin
            mix = acc[0] ^ d[0];
            acc = acc >> 1;
            if (mix) begin
                acc = acc ^ CRC_POLY_REFL;
            end
            d = d >> 1;
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

### rtl/tssd_if.sv
// valid/ready channels of the scratchpad decoder: byte input and result output
// depends on tssd_pkg
`default_nettype none

interface tssd_in_if import tssd_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface tssd_out_if import tssd_pkg::*;;
    logic                     valid;
    logic                     ready;
    t_status                  status;
    logic signed [MDEG_W-1:0] millidegrees;

    modport source (output valid, output status, output millidegrees, input ready);
    modport sink   (input valid, input status, input millidegrees, output ready);
endinterface

`default_nettype wire

### rtl/temp_sensor_scratchpad_decoder.sv
// Scratchpad decoder for a one-wire temperature sensor: top level.
// Depends on tssd_pkg, tssd_if, tssd_front, tssd_queue, tssd_back.
//
// Input channel i_byte_ch carries one scratchpad byte per item, in device
// order; frame_start marks byte 0 of a new frame. Bytes 0..7 feed a running
// crc-8 and the temperature and configuration bytes are captured. The ninth
// byte is compared with the crc and produces one item on o_result_ch:
// status (ok, crc mismatch, unknown resolution) and the temperature in
// millidegrees, zero on error. Bytes after the ninth without frame_start
// produce nothing.
// Throughput: one byte per cycle while ready is high. The edge that accepts the
// ninth byte writes the queue; the scaler result is then loaded into the output
// register once that register is empty or its result is being taken.
// The scaler does one 17x10 multiply per result.
// A two-entry job queue sits between the byte front end and the scaler;
// when the receiver stalls the output register holds, the queue fills and
// then ready drops, which happens only once three results are held back
// (one in the output register, two in the queue).
// Reset (synchronous, active low) clears the crc, byte count, captured
// bytes, queue and output valid.
`default_nettype none

module temp_sensor_scratchpad_decoder import tssd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tssd_in_if.sink    i_byte_ch,
    tssd_out_if.source o_result_ch
);

    logic push;
    t_job push_job;
    logic q_full;
    logic q_empty;
    logic pop;
    t_job pop_job;

    tssd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_ch (i_byte_ch),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_job     (push_job)
    );

    tssd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_job),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_pop_data  (pop_job),
        .o_empty     (q_empty)
    );

    tssd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_result_ch (o_result_ch)
    );

endmodule

`default_nettype wire

### rtl/tssd_front.sv
// front end: byte counting, running crc-8 and capture of temperature and config bytes
// depends on tssd_pkg and tssd_in_if; pushes one job per complete frame
`default_nettype none

module tssd_front import tssd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tssd_in_if.sink    i_byte_ch,
    input  wire logic  i_q_full,
    output logic       o_push,
    output t_job       o_job
);

    logic [7:0]       r_crc, n_crc;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_tlo, n_tlo;
    logic [7:0]       r_thi, n_thi;
    logic [7:0]       r_res, n_res;

    logic             accept;
    logic [7:0]       crc_eff;
    logic [IDX_W-1:0] idx_eff;

    // only the last byte needs queue space, but keep ready independent of data
    assign i_byte_ch.ready = !i_q_full;
    assign accept          = i_byte_ch.valid && i_byte_ch.ready;

    always_comb begin
        crc_eff = i_byte_ch.frame_start ? 8'h00 : r_crc;
        idx_eff = i_byte_ch.frame_start ? '0 : r_idx;

        n_crc  = r_crc;
        n_idx  = r_idx;
        n_tlo  = r_tlo;
        n_thi  = r_thi;
        n_res  = r_res;
        o_push = 1'b0;

        o_job.crc_ok   = (i_byte_ch.rx_byte == crc_eff);
        o_job.res_byte = r_res;
        o_job.raw      = {r_thi, r_tlo};

        if (accept) begin
            n_crc = crc_eff;
            n_idx = idx_eff;
            if (idx_eff < IDX_W'(LAST_IDX)) begin
                if (idx_eff == IDX_W'(0)) begin
                    n_tlo = i_byte_ch.rx_byte;
                end else if (idx_eff == IDX_W'(1)) begin
                    n_thi = i_byte_ch.rx_byte;
                end else if (idx_eff == IDX_W'(4)) begin
                    n_res = i_byte_ch.rx_byte;
                end
                n_crc = crc8_update(crc_eff, i_byte_ch.rx_byte);
                n_idx = idx_eff + IDX_W'(1);
            end else if (idx_eff == IDX_W'(LAST_IDX)) begin
                // crc byte: close the frame
                o_push = 1'b1;
                n_idx  = IDX_W'(FRAME_BYTES);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= '0;
            r_idx <= '0;
            r_tlo <= '0;
            r_thi <= '0;
            r_res <= '0;
        end else begin
            r_crc <= n_crc;
            r_idx <= n_idx;
            r_tlo <= n_tlo;
            r_thi <= n_thi;
            r_res <= n_res;
        end
    end

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_W'(FRAME_BYTES))
        else $error("byte index past frame length");

    a_push_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_idx == IDX_W'(FRAME_BYTES))
        else $error("frame not closed after push");

endmodule

`default_nettype wire

### rtl/tssd_queue.sv
// two-entry job queue between front end and scaler
// depends on tssd_pkg
`default_nettype none

module tssd_queue import tssd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_job       i_push_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_job       o_pop_data,
    output logic       o_empty
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job popped from empty queue");

endmodule

`default_nettype wire

### rtl/tssd_back.sv
// back end: resolution decode, scaling to millidegrees and the output register
// depends on tssd_pkg and tssd_out_if
`default_nettype none

module tssd_back import tssd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_empty,
    input  t_job       i_job,
    output logic       o_pop,
    tssd_out_if.source o_result_ch
);

    logic                     r_out_valid;
    t_status                  r_status, n_status;
    logic signed [MDEG_W-1:0] r_mdeg, n_mdeg;

    logic        neg;
    logic [16:0] mag;
    logic [16:0] sel;
    logic [9:0]  scale;
    logic        half;
    logic        known;
    logic [26:0] prod;
    logic [21:0] v;

    assign o_pop = !i_q_empty && (!r_out_valid || o_result_ch.ready);

    always_comb begin
        neg   = i_job.raw[15];
        mag   = neg ? (17'h10000 - {1'b0, i_job.raw}) : {1'b0, i_job.raw};
        sel   = mag;
        scale = SCALE_12;
        half  = 1'b0;
        known = 1'b1;
        unique case (i_job.res_byte)
            RES_CODE_9: begin
                sel   = mag >> 3;
                scale = SCALE_9;
            end
            RES_CODE_10: begin
                sel   = mag >> 2;
                scale = SCALE_10;
            end
            RES_CODE_11: begin
                sel   = mag >> 1;
                scale = SCALE_11;
            end
            RES_CODE_12: begin
                half = 1'b1;
            end
            default: begin
                known = 1'b0;
            end
        endcase
        prod = 27'(sel) * 27'(scale);
        v    = half ? prod[22:1] : prod[21:0];

        if (!i_job.crc_ok) begin
            n_status = ST_CRC;
            n_mdeg   = '0;
        end else if (!known) begin
            n_status = ST_RES;
            n_mdeg   = '0;
        end else begin
            n_status = ST_OK;
            n_mdeg   = neg ? -$signed(v) : $signed(v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= n_status;
            r_mdeg   <= n_mdeg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_result_ch.valid        = r_out_valid;
    assign o_result_ch.status       = r_status;
    assign o_result_ch.millidegrees = r_mdeg;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != ST_OK |-> r_mdeg == '0)
        else $error("error result carries a temperature");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_mdeg <= 22'sd2048000 && r_mdeg >= -22'sd2048000)
        else $error("temperature out of range");

endmodule

`default_nettype wire
